/* design/twf_pkg.sv */
`default_nettype none

package twf_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int VAR_W     = 63;
   localparam int RAD_W     = 2 * VAR_W;
   localparam int SQ_STEPS  = VAR_W;
   localparam int REM_W     = VAR_W + 2;
   localparam int DIV_STEPS = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] mean_u;
      logic signed [31:0] mean_up;
      logic signed [31:0] mean_u_sq;
      logic signed [31:0] mean_up_sq;
      logic signed [31:0] mean_u_up;
   } req_type;

   typedef struct packed {
      logic        [31:0] emittance;
      logic signed [31:0] alpha;
      logic        [31:0] beta;
      logic        [31:0] gamma;
      logic        [31:0] var_u;
      logic        [31:0] var_up;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [VAR_W-1:0] vu;
      logic [VAR_W-1:0] vup;
      logic [VAR_W-1:0] cmag;
      logic             cov_pos;
      logic [31:0]      var_u;
      logic [31:0]      var_up;
   } mom_type;

   function automatic logic [31:0] sat_u32(input logic [64:0] v);
      return (|v[64:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

`default_nettype wire

/* design/twiss_from_beam_moments.sv */
// channel   dir   handshake              payload
// req       in    req_valid/req_stall    req_data  (five moments)
// rsp       out   rsp_valid/rsp_stall    rsp_data  (emittance, twiss, variances)
//
// one beat per cycle in each direction when nothing stalls
// a beat passes the front registers, the queue and the back, where the 63-step
// square root pipeline and the divider pipelines lie
// reset is synchronous and clears only valid bits, queue pointers and the queue count
// a 4-entry queue lets the front keep taking beats while rsp_stall holds the back
`default_nettype none

module twiss_from_beam_moments import twf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    mom_valid, q_full, q_empty, q_pop;
   mom_type mom_data, q_head;

   twf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mom_valid (mom_valid),
      .mom_data  (mom_data),
      .mom_full  (q_full)
   );

   twf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (mom_valid),
      .push_data  (mom_data),
      .full       (q_full),
      .empty      (q_empty),
      .pop        (q_pop),
      .head       (q_head)
   );

   twf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mom_empty (q_empty),
      .mom_head  (q_head),
      .mom_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_push_fills : assert property (@(posedge clock) disable iff (reset)
      mom_valid && !q_full |=> !q_empty)
      else $error("queue empty after a push");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> mom_valid && q_full)
      else $error("input stalled without a full queue");

   a_degenerate : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.emittance == '0 &&
         rsp_data.alpha == '0 && rsp_data.beta == '0 && rsp_data.gamma == '1)
      else $error("degenerate beat carries twiss values");

endmodule

`default_nettype wire

/* design/twf_front.sv */
`default_nettype none

module twf_front import twf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    mom_valid,
   output mom_type mom_data,
   input  logic    mom_full
);

   logic adv;

   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;

   logic signed [63:0] mu2_ff, mup2_ff, mumup_ff;
   logic signed [63:0] mu2_in, mup2_in, mumup_in;
   logic signed [31:0] m2u_ff, m2up_ff, muup_ff;

   mom_type mom_ff, mom_in;

   logic signed [64:0] du, dup, dc;
   logic        [64:0] du_mag, dup_mag, dc_mag;

   assign adv       = !(s2_vld_ff && mom_full);
   assign req_stall = !adv;
   assign mom_valid = s2_vld_ff;
   assign mom_data  = mom_ff;

   assign s1_vld_in = req_valid;
   assign s2_vld_in = s1_vld_ff;

   // squared and cross first moments
   assign mu2_in   = req_data.mean_u  * req_data.mean_u;
   assign mup2_in  = req_data.mean_up * req_data.mean_up;
   assign mumup_in = req_data.mean_u  * req_data.mean_up;

   // centred moments
   always_comb begin
      du  = (65'(m2u_ff)  <<< FRAC_BITS) - 65'(mu2_ff);
      dup = (65'(m2up_ff) <<< FRAC_BITS) - 65'(mup2_ff);
      dc  = (65'(muup_ff) <<< FRAC_BITS) - 65'(mumup_ff);
      du_mag  = du[64]  ? 65'(-du)  : 65'(du);
      dup_mag = dup[64] ? 65'(-dup) : 65'(dup);
      dc_mag  = dc[64]  ? 65'(-dc)  : 65'(dc);
      mom_in.vu      = du_mag[VAR_W-1:0];
      mom_in.vup     = dup_mag[VAR_W-1:0];
      mom_in.cmag    = dc_mag[VAR_W-1:0];
      mom_in.cov_pos = !dc[64] && (dc != '0);
      mom_in.var_u   = sat_u32(du_mag >> FRAC_BITS);
      mom_in.var_up  = sat_u32(dup_mag >> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu2_ff   <= mu2_in;
         mup2_ff  <= mup2_in;
         mumup_ff <= mumup_in;
         m2u_ff   <= req_data.mean_u_sq;
         m2up_ff  <= req_data.mean_up_sq;
         muup_ff  <= req_data.mean_u_up;
         mom_ff   <= mom_in;
      end
   end

endmodule

`default_nettype wire

/* design/twf_queue.sv */
`default_nettype none

module twf_queue import twf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  mom_type push_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output mom_type head
);

   mom_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;

   assign full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign push  = push_valid && !full;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/twf_div.sv */
`default_nettype none

module twf_div import twf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  logic [VAR_W-1:0] num,
   input  logic [VAR_W-1:0] den,
   output logic [31:0]      quo
);

   localparam int NW = VAR_W + FRAC_BITS;

   logic [NW-1:0] n_w;
   logic [NW-33:0] hi;

   logic [VAR_W-1:0] rem_ff [0:DIV_STEPS];
   logic [VAR_W-1:0] den_ff [0:DIV_STEPS];
   logic [31:0]      lo_ff  [0:DIV_STEPS];
   logic [31:0]      q_ff   [0:DIV_STEPS];
   logic             ovf_ff [0:DIV_STEPS];

   assign n_w = {num, {FRAC_BITS{1'b0}}};
   assign hi  = n_w[NW-1:32];

   // quotient of 2^32 or more saturates
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= VAR_W'(hi);
         den_ff[0] <= den;
         lo_ff[0]  <= n_w[31:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= (VAR_W'(hi) >= den);
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [VAR_W:0]   r2;
      logic             ge;
      logic [VAR_W:0]   diff;

      assign r2   = {rem_ff[j], lo_ff[j][31]};
      assign ge   = (r2 >= {1'b0, den_ff[j]});
      assign diff = r2 - {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? diff[VAR_W-1:0] : r2[VAR_W-1:0];
            den_ff[j+1] <= den_ff[j];
            lo_ff[j+1]  <= {lo_ff[j][30:0], 1'b0};
            q_ff[j+1]   <= {q_ff[j][30:0], ge};
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign quo = ovf_ff[DIV_STEPS] ? 32'hFFFF_FFFF : q_ff[DIV_STEPS];

endmodule

`default_nettype wire

/* design/twf_back.sv */
`default_nettype none

module twf_back import twf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    mom_empty,
   input  mom_type mom_head,
   output logic    mom_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int BL = 3 + (SQ_STEPS + 1) + (DIV_STEPS + 1);

   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } prod_type;

   typedef struct packed {
      mom_type mom;
      logic    deg;
   } sq_side_type;

   typedef struct packed {
      logic        deg;
      logic        cov_pos;
      logic [31:0] emit;
      logic [31:0] var_u;
      logic [31:0] var_up;
   } tail_type;

   logic          adv;
   logic [BL-1:0] vld_ff, vld_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff, rsp_data_in;

   prod_type pab_ff, pcc_ff, pab_in, pcc_in;
   mom_type  m1_ff, m2_ff, m3_ff;

   logic [64:0]      mid_ab_ff, mid_cc_ff;
   logic [RAD_W-1:0] lohi_ab_ff, lohi_cc_ff;
   logic [RAD_W-1:0] ab_ff, cc_ff, ab_in, cc_in;

   logic [RAD_W-1:0] rad_ff  [0:SQ_STEPS];
   logic [REM_W-1:0] sqr_ff  [0:SQ_STEPS];
   logic [VAR_W-1:0] root_ff [0:SQ_STEPS];
   sq_side_type      sqs_ff  [0:SQ_STEPS];

   tail_type tail_ff [0:DIV_STEPS];
   tail_type tail_in;
   tail_type t_out;

   logic [31:0] qa, qb, qg, amag;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign mom_pop   = adv && !mom_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign vld_in    = {vld_ff[BL-2:0], mom_pop};

   // partial products of var_u*var_up and cov*cov
   always_comb begin
      pab_in.p00 = 64'(mom_head.vu[31:0])        * 64'(mom_head.vup[31:0]);
      pab_in.p01 = 64'(mom_head.vu[31:0])        * 64'(mom_head.vup[VAR_W-1:32]);
      pab_in.p10 = 64'(mom_head.vu[VAR_W-1:32])  * 64'(mom_head.vup[31:0]);
      pab_in.p11 = 64'(mom_head.vu[VAR_W-1:32])  * 64'(mom_head.vup[VAR_W-1:32]);
      pcc_in.p00 = 64'(mom_head.cmag[31:0])       * 64'(mom_head.cmag[31:0]);
      pcc_in.p01 = 64'(mom_head.cmag[31:0])       * 64'(mom_head.cmag[VAR_W-1:32]);
      pcc_in.p10 = 64'(mom_head.cmag[VAR_W-1:32]) * 64'(mom_head.cmag[31:0]);
      pcc_in.p11 = 64'(mom_head.cmag[VAR_W-1:32]) * 64'(mom_head.cmag[VAR_W-1:32]);
   end

   assign ab_in = RAD_W'(128'(lohi_ab_ff) + (128'(mid_ab_ff) << 32));
   assign cc_in = RAD_W'(128'(lohi_cc_ff) + (128'(mid_cc_ff) << 32));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[BL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pab_ff     <= pab_in;
         pcc_ff     <= pcc_in;
         m1_ff      <= mom_head;
         mid_ab_ff  <= 65'(pab_ff.p01) + 65'(pab_ff.p10);
         mid_cc_ff  <= 65'(pcc_ff.p01) + 65'(pcc_ff.p10);
         lohi_ab_ff <= {pab_ff.p11[RAD_W-65:0], pab_ff.p00};
         lohi_cc_ff <= {pcc_ff.p11[RAD_W-65:0], pcc_ff.p00};
         m2_ff      <= m1_ff;
         ab_ff      <= ab_in;
         cc_ff      <= cc_in;
         m3_ff      <= m2_ff;
         rad_ff[0]      <= ab_ff - cc_ff;
         sqr_ff[0]      <= '0;
         root_ff[0]     <= '0;
         sqs_ff[0].mom  <= m3_ff;
         sqs_ff[0].deg  <= (ab_ff <= cc_ff);
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [REM_W+1:0] r2, tr, diff;
      logic             ge;

      assign r2   = {sqr_ff[k], rad_ff[k][RAD_W-1-2*k -: 2]};
      assign tr   = {2'b00, root_ff[k], 2'b01};
      assign ge   = (r2 >= tr);
      assign diff = r2 - tr;

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k+1]  <= rad_ff[k];
            sqr_ff[k+1]  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
            root_ff[k+1] <= {root_ff[k][VAR_W-2:0], ge};
            sqs_ff[k+1]  <= sqs_ff[k];
         end
      end
   end

   twf_div #(.FRAC_BITS(FRAC_BITS)) u_div_alpha (
      .clock (clock),
      .en    (adv),
      .num   (sqs_ff[SQ_STEPS].mom.cmag),
      .den   (root_ff[SQ_STEPS]),
      .quo   (qa)
   );

   twf_div #(.FRAC_BITS(FRAC_BITS)) u_div_beta (
      .clock (clock),
      .en    (adv),
      .num   (sqs_ff[SQ_STEPS].mom.vu),
      .den   (root_ff[SQ_STEPS]),
      .quo   (qb)
   );

   twf_div #(.FRAC_BITS(FRAC_BITS)) u_div_gamma (
      .clock (clock),
      .en    (adv),
      .num   (sqs_ff[SQ_STEPS].mom.vup),
      .den   (root_ff[SQ_STEPS]),
      .quo   (qg)
   );

   always_comb begin
      tail_in.deg     = sqs_ff[SQ_STEPS].deg;
      tail_in.cov_pos = sqs_ff[SQ_STEPS].mom.cov_pos;
      tail_in.emit    = sat_u32(65'(root_ff[SQ_STEPS] >> FRAC_BITS));
      tail_in.var_u   = sqs_ff[SQ_STEPS].mom.var_u;
      tail_in.var_up  = sqs_ff[SQ_STEPS].mom.var_up;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_ff[0] <= tail_in;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_tail
      always_ff @(posedge clock) begin
         if (adv) begin
            tail_ff[j+1] <= tail_ff[j];
         end
      end
   end

   assign t_out = tail_ff[DIV_STEPS];

   always_comb begin
      amag = (qa > 32'h8000_0000) ? 32'h8000_0000 : qa;
      rsp_data_in.var_u      = t_out.var_u;
      rsp_data_in.var_up     = t_out.var_up;
      rsp_data_in.degenerate = t_out.deg;
      if (t_out.deg) begin
         rsp_data_in.emittance = '0;
         rsp_data_in.alpha     = '0;
         rsp_data_in.beta      = '0;
         rsp_data_in.gamma     = 32'hFFFF_FFFF;
      end else begin
         rsp_data_in.emittance = t_out.emit;
         if (t_out.cov_pos) begin
            rsp_data_in.alpha = -amag;
         end else begin
            rsp_data_in.alpha = (amag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : amag;
         end
         rsp_data_in.beta  = qb;
         rsp_data_in.gamma = qg;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

/* tb/twiss_from_beam_moments_test.sv */
`default_nettype none

module twiss_from_beam_moments_test;
   import twf_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 104;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   twiss_from_beam_moments dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rsp_type twiss_expected[$];
   int      mismatches = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      degenerate_seen = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h want %h", beats_out, what, got, want);
      mismatches++;
   endtask

   // floor(sqrt(d)) for d below 2^126
   function automatic logic [63:0] isqrt(input logic [127:0] d);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= d) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic [127:0] v);
      return (|v[127:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic rsp_type twiss_of(input req_type m);
      rsp_type          r;
      logic signed [127:0] mu, mup, vus, vups, cov;
      logic [127:0]     vu, vup, cmag, ab, cc, s, q;
      mu   = 128'(m.mean_u);
      mup  = 128'(m.mean_up);
      vus  = (128'(m.mean_u_sq) <<< FB) - mu * mu;
      vups = (128'(m.mean_up_sq) <<< FB) - mup * mup;
      cov  = (128'(m.mean_u_up) <<< FB) - mu * mup;
      vu   = vus < 0 ? -vus : vus;
      vup  = vups < 0 ? -vups : vups;
      cmag = cov < 0 ? -cov : cov;
      ab   = vu * vup;
      cc   = cmag * cmag;
      r.var_u  = sat32(vu >> FB);
      r.var_up = sat32(vup >> FB);
      if (ab <= cc) begin
         r.emittance = '0;
         r.alpha = '0;
         r.beta = '0;
         r.gamma = 32'hFFFF_FFFF;
         r.degenerate = 1'b1;
         return r;
      end
      s = 128'(isqrt(ab - cc));
      r.emittance = sat32(s >> FB);
      q = (cmag << FB) / s;
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      if (cov > 0) r.alpha = -q[31:0];
      else r.alpha = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      r.beta  = sat32((vu << FB) / s);
      r.gamma = sat32((vup << FB) / s);
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic req_type moments(input int mu, input int mup, input int m2u,
                                       input int m2up, input int muup);
      req_type m;
      m.mean_u = mu; m.mean_up = mup; m.mean_u_sq = m2u;
      m.mean_up_sq = m2up; m.mean_u_up = muup;
      return m;
   endfunction

   // well-formed beam: centred second moments above the square of the mean
   function automatic req_type random_beam();
      int mu, mup, su, sup, c;
      mu  = $signed($urandom_range(0, 4095)) - 2048;
      mup = $signed($urandom_range(0, 4095)) - 2048;
      su  = $urandom_range(1, 1 << $urandom_range(0, 22));
      sup = $urandom_range(1, 1 << $urandom_range(0, 22));
      c   = $signed($urandom_range(0, 2 * su)) - su;
      return moments(mu << 8, mup << 8,
                     ((mu * mu) >>> 0) + su, ((mup * mup) >>> 0) + sup, mu * mup / 256 + c);
   endfunction

   function automatic req_type random_item();
      if ($urandom_range(0, 99) < 75) return random_beam();
      return moments($urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type w;
         if (twiss_expected.size() == 0) begin
            $display("unexpected result beat %0d", beats_out);
            mismatches++;
         end else begin
            w = twiss_expected.pop_front();
            if (rsp_data.emittance !== w.emittance) report("emittance", rsp_data.emittance, w.emittance);
            if (rsp_data.alpha !== w.alpha) report("alpha", rsp_data.alpha, w.alpha);
            if (rsp_data.beta !== w.beta) report("beta", rsp_data.beta, w.beta);
            if (rsp_data.gamma !== w.gamma) report("gamma", rsp_data.gamma, w.gamma);
            if (rsp_data.var_u !== w.var_u) report("var_u", rsp_data.var_u, w.var_u);
            if (rsp_data.var_up !== w.var_up) report("var_up", rsp_data.var_up, w.var_up);
            if (rsp_data.degenerate !== w.degenerate)
               report("degenerate", 32'(rsp_data.degenerate), 32'(w.degenerate));
            if (rsp_data.degenerate === 1'b1) degenerate_seen++;
         end
         beats_out++;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // valid stays up after the beat; idling or drain lowers it
   task automatic send(input req_type m, input rsp_type want, input bit typed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      twiss_expected.push_back(typed ? want : twiss_of(m));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_in++;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (twiss_expected.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   typedef struct {
      req_type m;
      bit      typed;
      rsp_type want;
   } row_type;

   rsp_type degenerate_zero;
   row_type directed[$];

   initial begin
      degenerate_zero = '{emittance: 0, alpha: 0, beta: 0, gamma: 32'hFFFF_FFFF,
                          var_u: 0, var_up: 0, degenerate: 1'b1};
      directed.push_back('{moments(0, 0, 0, 0, 0), 1, degenerate_zero});
      directed.push_back('{moments(32'sh10000, 0, 32'sh10000, 0, 0), 1, degenerate_zero});
      directed.push_back('{moments(0, 0, 32'sh10000, 32'sh10000, 0), 1,
                           '{32'h10000, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0}});
      directed.push_back('{moments(0, 0, 32'sh10000, 32'sh10000, 32'sh10000), 1,
                           '{0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 32'h10000, 1}});
      directed.push_back('{moments(0, 0, 32'sh10000, 32'sh10000, 32'sh8000), 0, '0});
      directed.push_back('{moments(0, 0, 32'sh10000, 32'sh10000, -32'sh8000), 0, '0});
      directed.push_back('{moments(0, 0, -32'sh10000, -32'sh10000, 0), 0, '0});
      directed.push_back('{moments(0, 0, 1, 1, 0), 0, '0});
      directed.push_back('{moments(0, 0, 1, 32'sh7FFF_FFFF, 0), 0, '0});
      directed.push_back('{moments(0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0), 0, '0});
      directed.push_back('{moments(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                   32'sh8000_0000, 32'sh8000_0000), 0, '0});
      directed.push_back('{moments(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, '0});
      directed.push_back('{moments(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                   32'sh7FFF_FFFF, 32'sh8000_0000), 0, '0});
      directed.push_back('{moments(-1, -1, -1, -1, -1), 0, '0});
      directed.push_back('{moments(0, 0, 1, 32'sh7FFF_FFFF, 1), 0, '0});
      directed.push_back('{moments(0, 0, 3, 3, 32'sh7FFF_FFFF), 0, '0});
      directed.push_back('{moments(0, 0, 3, 3, 32'sh8000_0000), 0, '0});
      directed.push_back('{moments(0, 0, 32'sh7FFF_FFFF, 1, 0), 0, '0});
      directed.push_back('{moments(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                   32'shAAAA_AAAA, 32'sh5555_5555), 0, '0});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send(directed[i].m, directed[i].want, directed[i].typed);
      drain();

      // long receiver hold-off while the sender keeps offering beats
      hold_cycles = 400;
      repeat (150) send(random_item(), '0, 0);
      drain();

      send_idle_pct = 27; recv_idle_pct = 60;
      repeat (430) send(random_item(), '0, 0);
      drain();
      send_idle_pct = 60; recv_idle_pct = 27;
      repeat (430) send(random_item(), '0, 0);
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (420) begin
         // back to back: keep valid up, no lowering in between
         req_valid <= 1'b1;
         req_data  <= random_item();
         @(posedge clock);
         while (req_stall) @(posedge clock);
         twiss_expected.push_back(twiss_of(req_data));
         beats_in++;
         @(negedge clock);
      end
      drain();
      repeat (LATENCY + 20) @(negedge clock);

      $display("%0d moment sets sent, %0d results checked, %0d degenerate beams",
               beats_in, beats_out, degenerate_seen);
      if (mismatches == 0 && twiss_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, twiss_expected.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
